// ===== design/iircx_pkg.sv =====
// ---------------------------------------------------------------------------
// iircx_pkg: shared types and constants
// Field widths, register codes, sequencer states and the control bundle of
// the shared multiply-accumulate unit of the complex IIR cascade.
// ---------------------------------------------------------------------------
package iircx_pkg;

   // Parameter defaults
   localparam int CHANNELS_DEF   = 16;
   localparam int MAX_STAGES_DEF = 3;

   // Field widths
   localparam int SAMPLE_W  = 24;
   localparam int CH_W      = 4;
   localparam int REG_W     = 32;
   localparam int CSR_IDX_W = 3;
   localparam int STAGE_W   = 2;
   localparam int COEF_REGS = 3;

   // Datapath widths and fixed-point positions
   localparam int DATA_W     = 32;   // delay part, 8 fraction bits
   localparam int COEF_W     = 16;   // Q2.14
   localparam int COEF_FRAC  = 14;
   localparam int GAIN_SHIFT = 8;    // Q16.16 times integer down to Q.8
   localparam int OUT_SHIFT  = 8;    // Q.8 down to integer
   localparam int PROD_W     = 2 * DATA_W;
   localparam int ACC_W      = 52;

   // Multiply-accumulate terms per section and counter widths
   localparam int MAC_TERMS = 8;
   localparam int STEP_W    = 4;
   localparam int TERM_W    = 3;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STAGE_COUNT = 3'd0,
      CSR_GAIN        = 3'd1,
      CSR_ZERO_0      = 3'd2,
      CSR_ZERO_1      = 3'd3,
      CSR_ZERO_2      = 3'd4,
      CSR_POLE_0      = 3'd5,
      CSR_POLE_1      = 3'd6,
      CSR_POLE_2      = 3'd7
   } csr_index_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GAIN,
      ST_XLOAD,
      ST_BLOAD,
      ST_MAC,
      ST_ROUND,
      ST_STORE,
      ST_TAIL,
      ST_EMIT
   } state_type;

   // Control of the shared multiply-accumulate unit
   typedef struct packed {
      logic load;      // preset both accumulators from the section input
      logic mul_en;    // capture a new product
      logic acc_en;    // fold the held product into one accumulator
      logic acc_im;    // 1 selects the imaginary accumulator
      logic acc_sub;   // 1 subtracts the product
   } mac_ctl_type;

   typedef struct packed {
      logic acc_im;
      logic acc_sub;
   } term_type;

   // Where each of the eight complex products goes:
   //   re: -zr*ar +zi*ai +pr*br -pi*bi   im: -zr*ai -zi*ar +pr*bi +pi*br
   function automatic term_type mac_term(input logic [TERM_W-1:0] k);
      term_type t;
      case (k)
         3'd0:    t = '{acc_im: 1'b0, acc_sub: 1'b1};
         3'd1:    t = '{acc_im: 1'b0, acc_sub: 1'b0};
         3'd2:    t = '{acc_im: 1'b0, acc_sub: 1'b0};
         3'd3:    t = '{acc_im: 1'b0, acc_sub: 1'b1};
         3'd4:    t = '{acc_im: 1'b1, acc_sub: 1'b1};
         3'd5:    t = '{acc_im: 1'b1, acc_sub: 1'b1};
         3'd6:    t = '{acc_im: 1'b1, acc_sub: 1'b0};
         default: t = '{acc_im: 1'b1, acc_sub: 1'b0};
      endcase
      return t;
   endfunction

endpackage

// ===== design/iircx_ram.sv =====
// ---------------------------------------------------------------------------
// iircx_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module iircx_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word when enabled, read one word every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/iircx_mac.sv =====
// ---------------------------------------------------------------------------
// iircx_mac: shared multiplier and complex accumulator
// One registered 32x32 signed multiplier; its product is folded into the
// real or imaginary accumulator one term per cycle while acc_en is high.
// ---------------------------------------------------------------------------
module iircx_mac (
   input  logic                                clock,
   input  iircx_pkg::mac_ctl_type              ctl,
   input  logic signed [iircx_pkg::DATA_W-1:0] op_a,
   input  logic signed [iircx_pkg::DATA_W-1:0] op_b,
   input  logic signed [iircx_pkg::DATA_W-1:0] init_re,
   input  logic signed [iircx_pkg::DATA_W-1:0] init_im,
   output logic signed [iircx_pkg::PROD_W-1:0] prod,
   output logic signed [iircx_pkg::ACC_W-1:0]  acc_re,
   output logic signed [iircx_pkg::ACC_W-1:0]  acc_im
);
   import iircx_pkg::*;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_re_ff, acc_re_in;
   logic signed [ACC_W-1:0]  acc_im_ff, acc_im_in;
   logic signed [ACC_W-1:0]  addend;
   logic signed [ACC_W-1:0]  acc_sel;
   logic signed [ACC_W-1:0]  acc_new;

   // Pick the accumulator and add or subtract the held product
   always_comb begin
      prod_in   = prod_ff;
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      addend    = ACC_W'(prod_ff);
      acc_sel   = ctl.acc_im ? acc_im_ff : acc_re_ff;
      acc_new   = ctl.acc_sub ? (acc_sel - addend) : (acc_sel + addend);

      if (ctl.mul_en) begin
         prod_in = op_a * op_b;
      end

      if (ctl.load) begin
         acc_re_in = ACC_W'(init_re) <<< COEF_FRAC;
         acc_im_in = ACC_W'(init_im) <<< COEF_FRAC;
      end else if (ctl.acc_en) begin
         if (ctl.acc_im) begin
            acc_im_in = acc_new;
         end else begin
            acc_re_in = acc_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      acc_re_ff <= acc_re_in;
      acc_im_ff <= acc_im_in;
   end

   assign prod   = prod_ff;
   assign acc_re = acc_re_ff;
   assign acc_im = acc_im_ff;

endmodule

// ===== design/iir_cascade_complex_first_order.sv =====
// ---------------------------------------------------------------------------
// iir_cascade_complex_first_order: multichannel complex IIR cascade
// Scales a sample by a real gain and runs it through up to three complex
// first-order sections, each channel with its own delay values.
// ---------------------------------------------------------------------------
// Usage
//   req_*  input items: action (0 filter, 1 clear all delays), channel and a
//          signed 24-bit sample. Accepted when req_valid and req_ready.
//   rsp_*  result items: channel, saturated real output and a clip flag.
//          Clear items and items for an absent channel give no result.
//   csr_*  register writes, taken at any edge with csr_wr_en high; write
//          them only while the block is idle.
// Sequence
//   A filter item with n active sections goes from accept to the result
//   register through a gain multiply, an operand load, per section one
//   delay read, eight products through the single shared multiplier, an
//   accumulate drain and rounding, then store and output. The first item
//   on a channel after reset or a clear also zeroes each unused delay
//   slot. Pass-through (n = 0) goes straight to output. The sequencer
//   takes no new item until it is back in idle; clear items and items for
//   an absent channel leave it idle.
//   req_ready is high only while the sequencer is idle.
// Reset and stall
//   Reset zeroes all delays at once through per-channel valid bits, so no
//   clearing pass is needed. A finished result waits in the output register
//   and a new item is still accepted; the sequencer holds its next result
//   until the receiver has taken the previous one.
// ---------------------------------------------------------------------------
module iir_cascade_complex_first_order #(
   parameter int CHANNELS   = iircx_pkg::CHANNELS_DEF,
   parameter int MAX_STAGES = iircx_pkg::MAX_STAGES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input items
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_action,
   input  logic [iircx_pkg::CH_W-1:0]            req_channel,
   input  logic signed [iircx_pkg::SAMPLE_W-1:0] req_sample_value,
   // result items
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [iircx_pkg::CH_W-1:0]            rsp_channel_out,
   output logic signed [iircx_pkg::SAMPLE_W-1:0] rsp_filtered_value,
   output logic                                  rsp_saturated,
   // register writes
   input  logic                                  csr_wr_en,
   input  logic [iircx_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [iircx_pkg::REG_W-1:0]           csr_wdata
);
   import iircx_pkg::*;

   // Store geometry: one row of slots per channel that the port can name
   localparam int ROWS    = (CHANNELS < (1 << CH_W)) ? CHANNELS : (1 << CH_W);
   localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SLOT_W  = $clog2(MAX_STAGES + 1);
   localparam int ADDR_W  = ROW_W + SLOT_W;
   localparam int DEPTH   = 1 << ADDR_W;
   localparam int ENTRY_W = 2 * DATA_W;

   // Rounding and saturation constants
   localparam logic signed [PROD_W-1:0] GAIN_HALF = PROD_W'(1) <<< (GAIN_SHIFT - 1);
   localparam logic signed [ACC_W-1:0]  ACC_HALF  = ACC_W'(1) <<< (COEF_FRAC - 1);
   localparam logic signed [DATA_W:0]   OUT_HALF  = (DATA_W + 1)'(1) <<< (OUT_SHIFT - 1);
   localparam logic signed [PROD_W-1:0] DATA_HI   = (PROD_W'(1) <<< (DATA_W - 1)) - PROD_W'(1);
   localparam logic signed [PROD_W-1:0] DATA_LO   = -(PROD_W'(1) <<< (DATA_W - 1));
   localparam logic signed [DATA_W:0]   OUT_HI    =
      ((DATA_W + 1)'(1) <<< (SAMPLE_W - 1)) - (DATA_W + 1)'(1);
   localparam logic signed [DATA_W:0]   OUT_LO    = -((DATA_W + 1)'(1) <<< (SAMPLE_W - 1));

   typedef struct packed {
      logic                     clip;
      logic signed [DATA_W-1:0] value;
   } data_sat_type;

   function automatic data_sat_type sat_data(input logic signed [PROD_W-1:0] v);
      data_sat_type r;
      if (v > DATA_HI) begin
         r.clip  = 1'b1;
         r.value = DATA_W'(DATA_HI);
      end else if (v < DATA_LO) begin
         r.clip  = 1'b1;
         r.value = DATA_W'(DATA_LO);
      end else begin
         r.clip  = 1'b0;
         r.value = DATA_W'(v);
      end
      return r;
   endfunction

   // Registers
   state_type                 state_ff, state_in;
   logic [STAGE_W-1:0]        stage_count_ff;
   logic signed [REG_W-1:0]   gain_ff;
   logic [REG_W-1:0]          zero_ff [COEF_REGS];
   logic [REG_W-1:0]          pole_ff [COEF_REGS];
   logic [ROWS-1:0]           row_valid_ff, row_valid_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0]           rsp_channel_ff, rsp_channel_in;
   logic signed [SAMPLE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                      rsp_sat_ff, rsp_sat_in;

   logic [CH_W-1:0]           ch_ff, ch_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [STAGE_W-1:0]        nstg_ff, nstg_in;
   logic                      pass_ff, pass_in;
   logic                      rowv_ff, rowv_in;
   logic                      flag_ff, flag_in;
   logic [STAGE_W-1:0]        stage_ff, stage_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic signed [DATA_W-1:0]  xr_ff, xr_in, xi_ff, xi_in;
   logic signed [DATA_W-1:0]  ar_ff, ar_in, ai_ff, ai_in;
   logic signed [DATA_W-1:0]  br_ff, br_in, bi_ff, bi_in;

   // Shared unit and store connections
   mac_ctl_type               mac_ctl;
   logic signed [DATA_W-1:0]  op_a, op_b;
   logic signed [PROD_W-1:0]  prod;
   logic signed [ACC_W-1:0]   acc_re, acc_im;
   logic                      wr_en;
   logic [STAGE_W-1:0]        wr_slot, rd_slot;
   logic [ENTRY_W-1:0]        wr_data, rd_data, rd_mask;
   logic [ADDR_W-1:0]         wr_addr, rd_addr;

   // Datapath helpers
   logic                      in_range;
   logic [STAGE_W-1:0]        n_eff;
   logic [REG_W-1:0]          zero_sel, pole_sel;
   logic signed [COEF_W-1:0]  zr, zi, pr, pi;
   logic signed [COEF_W-1:0]  coef;
   term_type                  term;
   logic signed [PROD_W-1:0]  gain_sum, gain_shr;
   data_sat_type              gain_sat;
   logic signed [ACC_W-1:0]   re_sum, re_shr, im_sum, im_shr;
   data_sat_type              yr_sat, yi_sat;
   logic signed [DATA_W:0]    out_sum, out_shr;
   logic                      out_clip;
   logic signed [SAMPLE_W-1:0] out_value;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_count_ff <= '0;
         gain_ff        <= REG_W'(65536);
         for (int i = 0; i < COEF_REGS; i++) begin
            zero_ff[i] <= '0;
            pole_ff[i] <= '0;
         end
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_STAGE_COUNT: stage_count_ff <= csr_wdata[STAGE_W-1:0];
            CSR_GAIN:        gain_ff        <= csr_wdata;
            CSR_ZERO_0:      zero_ff[0]     <= csr_wdata;
            CSR_ZERO_1:      zero_ff[1]     <= csr_wdata;
            CSR_ZERO_2:      zero_ff[2]     <= csr_wdata;
            CSR_POLE_0:      pole_ff[0]     <= csr_wdata;
            CSR_POLE_1:      pole_ff[1]     <= csr_wdata;
            CSR_POLE_2:      pole_ff[2]     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Effective section count and channel check
   assign n_eff    = (32'(stage_count_ff) > MAX_STAGES) ? STAGE_W'(MAX_STAGES)
                                                        : stage_count_ff;
   assign in_range = 32'(req_channel) < CHANNELS;

   // Coefficients of the current section
   assign zero_sel = zero_ff[stage_ff];
   assign pole_sel = pole_ff[stage_ff];
   assign zr       = zero_sel[REG_W-1:COEF_W];
   assign zi       = zero_sel[COEF_W-1:0];
   assign pr       = pole_sel[REG_W-1:COEF_W];
   assign pi       = pole_sel[COEF_W-1:0];

   // Delays of a channel never written since reset or clear read as zero
   assign rd_mask = rowv_ff ? rd_data : '0;

   // Gain product down to Q.8
   always_comb begin
      gain_sum = prod + GAIN_HALF;
      gain_shr = gain_sum >>> GAIN_SHIFT;
      gain_sat = sat_data(gain_shr);
   end

   // Section output: round Q.22 sums down to Q.8
   always_comb begin
      re_sum = acc_re + ACC_HALF;
      re_shr = re_sum >>> COEF_FRAC;
      im_sum = acc_im + ACC_HALF;
      im_shr = im_sum >>> COEF_FRAC;
      yr_sat = sat_data(PROD_W'(re_shr));
      yi_sat = sat_data(PROD_W'(im_shr));
   end

   // Final real part down to integer, saturated to the sample width
   always_comb begin
      out_sum = (DATA_W + 1)'(xr_ff) + OUT_HALF;
      out_shr = out_sum >>> OUT_SHIFT;
      if (out_shr > OUT_HI) begin
         out_clip  = 1'b1;
         out_value = SAMPLE_W'(OUT_HI);
      end else if (out_shr < OUT_LO) begin
         out_clip  = 1'b1;
         out_value = SAMPLE_W'(OUT_LO);
      end else begin
         out_clip  = 1'b0;
         out_value = SAMPLE_W'(out_shr);
      end
   end

   // Operand pair of each product step
   always_comb begin
      term = mac_term(TERM_W'(step_ff - STEP_W'(1)));
      case (step_ff[TERM_W-1:0])
         3'd0:    begin op_a = ar_ff; coef = zr; end
         3'd1:    begin op_a = ai_ff; coef = zi; end
         3'd2:    begin op_a = br_ff; coef = pr; end
         3'd3:    begin op_a = bi_ff; coef = pi; end
         3'd4:    begin op_a = ai_ff; coef = zr; end
         3'd5:    begin op_a = ar_ff; coef = zi; end
         3'd6:    begin op_a = bi_ff; coef = pr; end
         default: begin op_a = br_ff; coef = pi; end
      endcase
      op_b = DATA_W'(coef);
      if (state_ff == ST_GAIN) begin
         op_a = DATA_W'(sample_ff);
         op_b = gain_ff;
      end
   end

   // Sequencer: next state and outputs
   always_comb begin
      state_in       = state_ff;
      row_valid_in   = row_valid_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_channel_in = rsp_channel_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_sat_in     = rsp_sat_ff;
      ch_in          = ch_ff;
      sample_in      = sample_ff;
      nstg_in        = nstg_ff;
      pass_in        = pass_ff;
      rowv_in        = rowv_ff;
      flag_in        = flag_ff;
      stage_in       = stage_ff;
      step_in        = step_ff;
      xr_in          = xr_ff;
      xi_in          = xi_ff;
      ar_in          = ar_ff;
      ai_in          = ai_ff;
      br_in          = br_ff;
      bi_in          = bi_ff;
      mac_ctl        = '0;
      wr_en          = 1'b0;
      wr_slot        = stage_ff;
      wr_data        = {xr_ff, xi_ff};
      rd_slot        = '0;
      req_ready      = 1'b0;

      // drop the result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_action) begin
                  row_valid_in = '0;
               end else if (in_range) begin
                  ch_in     = req_channel;
                  sample_in = req_sample_value;
                  nstg_in   = n_eff;
                  rowv_in   = row_valid_ff[req_channel[ROW_W-1:0]];
                  flag_in   = 1'b0;
                  pass_in   = (n_eff == '0);
                  state_in  = (n_eff == '0) ? ST_EMIT : ST_GAIN;
               end
            end
         end
         ST_GAIN: begin
            // multiply sample by gain, fetch slot 0
            mac_ctl.mul_en = 1'b1;
            rd_slot        = '0;
            state_in       = ST_XLOAD;
         end
         ST_XLOAD: begin
            xr_in    = gain_sat.value;
            xi_in    = '0;
            flag_in  = flag_ff | gain_sat.clip;
            ar_in    = rd_mask[ENTRY_W-1:DATA_W];
            ai_in    = rd_mask[DATA_W-1:0];
            stage_in = '0;
            rd_slot  = STAGE_W'(1);
            state_in = ST_BLOAD;
         end
         ST_BLOAD: begin
            // previous output of this section; preset sums with the input
            br_in        = rd_mask[ENTRY_W-1:DATA_W];
            bi_in        = rd_mask[DATA_W-1:0];
            mac_ctl.load = 1'b1;
            step_in      = '0;
            state_in     = ST_MAC;
         end
         ST_MAC: begin
            // one product per step, folded in at the next step
            mac_ctl.mul_en  = (32'(step_ff) < MAC_TERMS);
            mac_ctl.acc_en  = (step_ff != '0);
            mac_ctl.acc_im  = term.acc_im;
            mac_ctl.acc_sub = term.acc_sub;
            step_in         = step_ff + STEP_W'(1);
            if (32'(step_ff) == MAC_TERMS) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            // round the output, store section input, advance to next section
            wr_en    = 1'b1;
            wr_slot  = stage_ff;
            xr_in    = yr_sat.value;
            xi_in    = yi_sat.value;
            flag_in  = flag_ff | yr_sat.clip | yi_sat.clip;
            ar_in    = br_ff;
            ai_in    = bi_ff;
            stage_in = stage_ff + STAGE_W'(1);
            rd_slot  = stage_ff + STAGE_W'(2);
            if ((STAGE_W + 1)'(stage_ff) + (STAGE_W + 1)'(1) < (STAGE_W + 1)'(nstg_ff)) begin
               state_in = ST_BLOAD;
            end else begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            // final output goes to the slot after the last section
            wr_en   = 1'b1;
            wr_slot = nstg_ff;
            if (!rowv_ff && (32'(nstg_ff) < MAX_STAGES)) begin
               stage_in = nstg_ff + STAGE_W'(1);
               state_in = ST_TAIL;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_TAIL: begin
            // zero unused slots of a fresh channel row
            wr_en   = 1'b1;
            wr_slot = stage_ff;
            wr_data = '0;
            if (32'(stage_ff) == MAX_STAGES) begin
               state_in = ST_EMIT;
            end else begin
               stage_in = stage_ff + STAGE_W'(1);
            end
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_channel_in = ch_ff;
               rsp_value_in   = pass_ff ? sample_ff : out_value;
               rsp_sat_in     = pass_ff ? 1'b0 : (flag_ff | out_clip);
               if (!pass_ff) begin
                  row_valid_in[ch_ff[ROW_W-1:0]] = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign wr_addr = {ch_ff[ROW_W-1:0], wr_slot[SLOT_W-1:0]};
   assign rd_addr = {ch_ff[ROW_W-1:0], rd_slot[SLOT_W-1:0]};

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_channel_ff <= rsp_channel_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_sat_ff     <= rsp_sat_in;
      ch_ff          <= ch_in;
      sample_ff      <= sample_in;
      nstg_ff        <= nstg_in;
      pass_ff        <= pass_in;
      rowv_ff        <= rowv_in;
      flag_ff        <= flag_in;
      stage_ff       <= stage_in;
      step_ff        <= step_in;
      xr_ff          <= xr_in;
      xi_ff          <= xi_in;
      ar_ff          <= ar_in;
      ai_ff          <= ai_in;
      br_ff          <= br_in;
      bi_ff          <= bi_in;
   end

   // Shared multiply-accumulate unit
   iircx_mac u_mac (
      .clock   (clock),
      .ctl     (mac_ctl),
      .op_a    (op_a),
      .op_b    (op_b),
      .init_re (xr_ff),
      .init_im (xi_ff),
      .prod    (prod),
      .acc_re  (acc_re),
      .acc_im  (acc_im)
   );

   // Per-channel delay store
   iircx_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_channel_out    = rsp_channel_ff;
   assign rsp_filtered_value = rsp_value_ff;
   assign rsp_saturated      = rsp_sat_ff;

endmodule

// ===== design/iircx_checker.sv =====
// ---------------------------------------------------------------------------
// iircx_checker: port-level checks for the complex IIR cascade
// Watches the top-level ports over time; bound to the top level below.
// ---------------------------------------------------------------------------
module iircx_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  req_action,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [iircx_pkg::CH_W-1:0]            rsp_channel_out,
   input logic signed [iircx_pkg::SAMPLE_W-1:0] rsp_filtered_value,
   input logic                                  rsp_saturated
);
   import iircx_pkg::*;

   // A stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_channel_out)
         && $stable(rsp_filtered_value) && $stable(rsp_saturated))
      else $error("result changed while stalled");

   // Reset empties the output register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A clear item leaves the block ready in the next cycle
   a_clear_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action |=> req_ready)
      else $error("block busy after clear item");

   // A new result comes only from the busy sequencer
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while sequencer idle");

endmodule

bind iir_cascade_complex_first_order iircx_checker u_iircx_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .req_action         (req_action),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_channel_out    (rsp_channel_out),
   .rsp_filtered_value (rsp_filtered_value),
   .rsp_saturated      (rsp_saturated)
);
